@@ sv/lta_pkg.sv @@
// ----------------------------------------------------------------------------
// lta_pkg
// Shared types and constants for the Langford term accumulator.
// ----------------------------------------------------------------------------
package lta_pkg;

  localparam int ROW_W      = 30;
  localparam int LOW_W      = 20;
  localparam int ORDER_W    = 5;
  localparam int PREFIX_W   = 30;
  localparam int LBC_W      = 5;
  localparam int V_W        = 32;
  localparam int WORD_W     = 32;
  localparam int WIDX_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_N       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_BIT_COUNT = 2'd2;

  localparam logic [ORDER_W-1:0] ORDER_RST = 5'd7;
  localparam logic [LBC_W-1:0]   LBC_RST   = 5'd7;

  typedef struct packed {
    logic [ROW_W-1:0] row_code;
    logic [LOW_W-1:0] low_index;
    logic             last_point;
  } in_word_t;

  typedef struct packed {
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] word_value;
    logic              last_word;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CORR,
    ST_MUL,
    ST_ACCUM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic corr;
    logic mul;
    logic accum;
    logic emit_adv;
  } cmd_t;

  typedef struct packed {
    logic keep;
    logic last;
    logic corr_done;
    logic word_last;
  } status_t;

endpackage

@@ sv/lta_ctrl.sv @@
// ----------------------------------------------------------------------------
// lta_ctrl
// Sequencer: steps one point through load, correlation, multiply, accumulate
// and result emission.
// ----------------------------------------------------------------------------
module lta_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  lta_pkg::status_t status,
  output lta_pkg::cmd_t    cmd
);

  lta_pkg::state_t state_r;
  lta_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lta_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      lta_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = lta_pkg::ST_LOAD;
        end
      end
      lta_pkg::ST_LOAD: begin
        cmd.load = 1'b1;
        if (status.keep) begin
          state_nxt = lta_pkg::ST_CORR;
        end else if (status.last) begin
          state_nxt = lta_pkg::ST_EMIT;
        end else begin
          state_nxt = lta_pkg::ST_IDLE;
        end
      end
      lta_pkg::ST_CORR: begin
        cmd.corr = 1'b1;
        if (status.corr_done) begin
          state_nxt = lta_pkg::ST_MUL;
        end
      end
      lta_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = lta_pkg::ST_ACCUM;
      end
      lta_pkg::ST_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = status.last ? lta_pkg::ST_EMIT : lta_pkg::ST_IDLE;
      end
      lta_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_adv = 1'b1;
          if (status.word_last) begin
            state_nxt = lta_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = lta_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/lta_datapath.sv @@
// ----------------------------------------------------------------------------
// lta_datapath
// Configuration registers, sequence builder, correlation unit, running
// product and wrapping accumulator.
// ----------------------------------------------------------------------------
module lta_datapath #(
  parameter int MAX_ORDER = 31,
  parameter int ACC_WORDS = 5
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [lta_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lta_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  lta_pkg::in_word_t                    in_data,
  input  lta_pkg::cmd_t                        cmd,
  output lta_pkg::status_t                     status,
  output lta_pkg::out_word_t                   out_data
);

  localparam int NW  = 2 * MAX_ORDER;             // sequence bits
  localparam int NB  = $clog2(MAX_ORDER + 1);     // order value
  localparam int IW  = $clog2(MAX_ORDER + 2);     // correlation index
  localparam int MW  = $clog2(2 * MAX_ORDER);     // factor magnitude
  localparam int SW  = MW + 2;                    // signed correlation
  localparam int ZW  = lta_pkg::WORD_W * ACC_WORDS;
  localparam int XW  = (ACC_WORDS > 1) ? $clog2(ACC_WORDS) : 1;
  localparam int UW  = lta_pkg::ROW_W + 1;

  // configuration
  logic [lta_pkg::ORDER_W-1:0]  order_n_r;
  logic [lta_pkg::PREFIX_W-1:0] prefix_high_r;
  logic [lta_pkg::LBC_W-1:0]    low_bit_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_n_r       <= lta_pkg::ORDER_RST;
      prefix_high_r   <= '0;
      low_bit_count_r <= lta_pkg::LBC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lta_pkg::CFG_ORDER_N:       order_n_r       <= cfg_data[lta_pkg::ORDER_W-1:0];
        lta_pkg::CFG_PREFIX_HIGH:   prefix_high_r   <= cfg_data[lta_pkg::PREFIX_W-1:0];
        lta_pkg::CFG_LOW_BIT_COUNT: low_bit_count_r <= cfg_data[lta_pkg::LBC_W-1:0];
        default: ;
      endcase
    end
  end

  // captured point
  logic [lta_pkg::ROW_W-1:0] u_r;
  logic [lta_pkg::LOW_W-1:0] low_r;
  logic                      last_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      u_r    <= in_data.row_code;
      low_r  <= in_data.low_index;
      last_r <= in_data.last_point;
    end
  end

  // sequence build
  logic [NB-1:0]             n_c;
  logic [lta_pkg::V_W-1:0]   pv_c;
  logic [lta_pkg::LOW_W-1:0] lowm_c;
  logic [lta_pkg::V_W-1:0]   v_c;
  logic [UW-1:0]             u2_c;
  logic [MAX_ORDER-1:0]      rev_c;
  logic [MAX_ORDER-1:0]      r_c;
  logic [MAX_ORDER-1:0]      allb_c;
  logic [MAX_ORDER-1:0]      o_c;
  logic [lta_pkg::V_W:0]     ev_c;
  logic [NW-1:0]             x_c;
  logic                      keep_c;

  always_comb begin
    if (order_n_r < lta_pkg::ORDER_W'(2)) begin
      n_c = NB'(2);
    end else if (order_n_r > lta_pkg::ORDER_W'(MAX_ORDER)) begin
      n_c = NB'(MAX_ORDER);
    end else begin
      n_c = order_n_r[NB-1:0];
    end

    pv_c = lta_pkg::V_W'(prefix_high_r) << low_bit_count_r;
    for (int b = 0; b < lta_pkg::LOW_W; b++) begin
      lowm_c[b] = low_r[b] & (b < int'(low_bit_count_r));
    end
    v_c    = pv_c | lta_pkg::V_W'(lowm_c);
    keep_c = v_c < lta_pkg::V_W'(u_r);

    u2_c = {u_r, 1'b0};
    for (int j = 0; j < MAX_ORDER; j++) begin
      rev_c[j]  = u2_c[MAX_ORDER-1-j];
      allb_c[j] = (j < int'(n_c));
    end
    r_c  = rev_c >> (NB'(MAX_ORDER) - n_c);
    o_c  = r_c[0] ? (r_c ^ allb_c) : r_c;
    ev_c = {v_c, 1'b0};

    x_c = '0;
    for (int j = 0; j < MAX_ORDER; j++) begin
      x_c[2*j]   = o_c[j] & allb_c[j];
      x_c[2*j+1] = ev_c[j] & allb_c[j];
    end
  end

  // correlation for the current index
  logic [NB-1:0]  n_r;
  logic [IW-1:0]  i_r;
  logic [NW-1:0]  x_r;
  logic [SW-1:0]  w_c;
  logic [NW-1:0]  d_c;
  logic [MW-1:0]  pc_c;
  logic [SW-1:0]  a_c;
  logic [SW-1:0]  an_c;
  logic           aneg_c;

  always_comb begin
    w_c  = SW'({n_r, 1'b0}) - SW'(i_r);
    d_c  = x_r ^ (x_r >> i_r);
    pc_c = '0;
    for (int b = 0; b < NW; b++) begin
      pc_c = pc_c + MW'(d_c[b] & (b < int'(w_c)));
    end
    a_c    = w_c - SW'({pc_c, 1'b0});
    aneg_c = a_c[SW-1];
    an_c   = -a_c;
  end

  // running product and accumulator
  logic [MW-1:0]    a_mag_r;
  logic             a_vld_r;
  logic             neg_r;
  logic [ZW-1:0]    z_r;
  logic [ZW+MW-1:0] prod_c;
  logic [ZW-1:0]    acc_r;
  logic [XW-1:0]    idx_r;
  logic             word_last_c;

  assign prod_c      = z_r * a_mag_r;
  assign word_last_c = (idx_r == XW'(ACC_WORDS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= x_c;
      n_r     <= n_c;
      i_r     <= IW'(2);
      z_r     <= ZW'(1);
      neg_r   <= ^x_c;
      a_vld_r <= 1'b0;
    end
    if (cmd.corr) begin
      a_mag_r <= aneg_c ? an_c[MW-1:0] : a_c[MW-1:0];
      a_vld_r <= 1'b1;
      neg_r   <= neg_r ^ aneg_c;
      i_r     <= i_r + IW'(1);
      if (a_vld_r) begin
        z_r <= prod_c[ZW-1:0];
      end
    end
    if (cmd.mul) begin
      z_r <= prod_c[ZW-1:0];
    end
  end

  // a zero factor leaves z at zero, so the add below is then a no-op
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      idx_r <= '0;
    end else if (cmd.accum) begin
      acc_r <= neg_r ? (acc_r - z_r) : (acc_r + z_r);
    end else if (cmd.emit_adv) begin
      if (word_last_c) begin
        idx_r <= '0;
        acc_r <= '0;
      end else begin
        idx_r <= idx_r + XW'(1);
      end
    end
  end

  logic [ZW-1:0] dbl_c;
  assign dbl_c = {acc_r[ZW-2:0], 1'b0};

  assign out_data.word_index = lta_pkg::WIDX_W'(idx_r);
  assign out_data.word_value = dbl_c[lta_pkg::WORD_W*idx_r +: lta_pkg::WORD_W];
  assign out_data.last_word  = word_last_c;

  assign status.keep      = keep_c;
  assign status.last      = last_r;
  assign status.corr_done = (i_r == (IW'(n_r) + IW'(1)));
  assign status.word_last = word_last_c;

endmodule

@@ sv/langford_term_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// langford_term_accumulator_core
// Signed Langford-pair term accumulator: one enumerated point per input word.
// ----------------------------------------------------------------------------
// Points: a kept point passes through load, the correlation loop, a final
//   multiply and accumulate before the next is accepted; a skipped point
//   leaves after load. The correlation loop forms one factor per cycle through
//   the shared popcount and the 160x6 product.
// Results: after a last point, ACC_WORDS words, one per cycle unless stalled.
// Reset (rst_n, synchronous, active low): accumulator cleared, controller
//   idle, order_n and low_bit_count set to 7, prefix_high to 0.
module langford_term_accumulator_core #(
  parameter int MAX_ORDER = 31,
  parameter int ACC_WORDS = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [lta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lta_pkg::CFG_DATA_W-1:0] cfg_data,
  // input points
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lta_pkg::in_word_t              in_data,
  // result words
  output logic                           out_valid,
  input  logic                           out_ready,
  output lta_pkg::out_word_t             out_data
);

  // Command and status between the sequencer and the datapath.
  lta_pkg::cmd_t    cmd;
  lta_pkg::status_t status;

  // Sequencer: hold in_ready only while idle, advance one phase per cycle
  // through the correlation loop, and present result words until the most
  // significant one is taken.
  lta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: build the interleaved sequence on load, form one correlation
  // per cycle, register its magnitude and fold it into the running product,
  // then add or subtract the product into the wrapping accumulator. The
  // doubled accumulator is read out word by word and dropped to zero after
  // the last word.
  lta_datapath #(
    .MAX_ORDER (MAX_ORDER),
    .ACC_WORDS (ACC_WORDS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

@@ tb/sv/tb_langford_term_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// tb_langford_term_accumulator_core
// Self-checking bench for the Langford term accumulator. Points are driven
// through the valid/ready input channel while a bit-accurate predictor in the
// bench folds each accepted point into its own 160-bit running sum. On every
// last point the predictor queues the five words of the doubled sum, and a
// monitor compares each accepted result word with the oldest queued one.
// ----------------------------------------------------------------------------
module tb_langford_term_accumulator_core;

  localparam int MAX_ORDER = 31;
  localparam int ACC_WORDS = 5;
  localparam int SUM_W     = lta_pkg::WORD_W * ACC_WORDS;
  // allowance for the slowest kept point at the largest order, plus margin
  localparam int SETTLE_CYCLES = MAX_ORDER + 16;

  localparam logic [lta_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam logic [lta_pkg::ROW_W-1:0]     ROW_MAX       = '1;
  localparam logic [lta_pkg::LOW_W-1:0]     LOW_MAX       = '1;
  localparam logic [lta_pkg::PREFIX_W-1:0]  PREFIX_MAX    = '1;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [lta_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [lta_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  lta_pkg::in_word_t              in_data;
  logic                           out_valid;
  logic                           out_ready;
  lta_pkg::out_word_t             out_data;

  // Shadow copy of the register file and of the accumulator
  logic [lta_pkg::ORDER_W-1:0]  order_q;
  logic [lta_pkg::PREFIX_W-1:0] prefix_q;
  logic [lta_pkg::LBC_W-1:0]    lbc_q;
  logic [SUM_W-1:0]             term_sum;

  // Result words still owed by the block, oldest first
  lta_pkg::out_word_t sum_words_due[$];
  lta_pkg::out_word_t due_w;

  int err_count;
  bit stall_en;

  langford_term_accumulator_core #(
    .MAX_ORDER (MAX_ORDER),
    .ACC_WORDS (ACC_WORDS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [6:0] ones64(input logic [63:0] x);
    logic [6:0] c;
    c = '0;
    for (int b = 0; b < 64; b++) c = c + 7'(x[b]);
    return c;
  endfunction

  // v: prefix above the low K bits of the index, cut to 32 bits. A count
  // above 20 still shifts the prefix; the index simply has no bits up there.
  function automatic logic [lta_pkg::V_W-1:0] v_of(input logic [lta_pkg::LOW_W-1:0] low);
    logic [63:0] lowmask;
    logic [63:0] wide;
    lowmask = (64'd1 << lbc_q) - 64'd1;
    wide    = ({34'd0, prefix_q} << lbc_q) | ({44'd0, low} & lowmask);
    return wide[lta_pkg::V_W-1:0];
  endfunction

  // Fold one point into the running sum; drop it when v is not below u or
  // when any correlation comes out at zero.
  function automatic void fold_point(input logic [lta_pkg::ROW_W-1:0] row,
                                     input logic [lta_pkg::LOW_W-1:0] low);
    int                        n;
    int                        w;
    int                        a;
    logic [lta_pkg::V_W-1:0]   v;
    logic [lta_pkg::V_W-1:0]   e;
    logic [lta_pkg::V_W-1:0]   r;
    logic [lta_pkg::V_W-1:0]   o;
    logic [lta_pkg::V_W-1:0]   allb;
    logic [63:0]               x;
    logic [63:0]               u2;
    logic [63:0]               m;
    logic [SUM_W-1:0]          prod;
    logic [SUM_W-1:0]          factor;
    logic [6:0]                ones;
    logic                      neg;

    // clamp the order into the range the block supports
    n = int'(order_q);
    if (n < 2) n = 2;
    if (n > MAX_ORDER) n = MAX_ORDER;

    v = v_of(low);
    if (v >= {2'b00, row}) return;

    // odd row: bit-reversed u<<1, complemented when its bit 0 is set
    u2 = {34'd0, row} << 1;
    r  = '0;
    for (int j = 0; j < n; j++) r[j] = u2[n-1-j];
    m    = (64'd1 << n) - 64'd1;
    allb = m[lta_pkg::V_W-1:0];
    o    = r[0] ? (r ^ allb) : r;
    e    = v << 1;

    // interleave: odd row on even bits, even row on odd bits
    x = '0;
    for (int j = 0; j < n; j++) begin
      x[2*j]   = o[j];
      x[2*j+1] = e[j];
    end

    prod = SUM_W'(1);
    neg  = 1'b0;
    for (int i = 2; i <= n + 1; i++) begin
      w    = 2 * n - i;
      m    = (64'd1 << w) - 64'd1;
      ones = ones64((x ^ (x >> i)) & m);
      a    = w - 2 * int'(ones);
      if (a == 0) return;
      if (a < 0) begin
        neg = ~neg;
        a   = -a;
      end
      factor = SUM_W'(a);
      prod   = prod * factor;
    end
    ones = ones64(x);
    if (ones[0]) neg = ~neg;
    term_sum = neg ? term_sum - prod : term_sum + prod;
  endfunction

  // Queue the doubled sum as little-endian words, then start a fresh sum
  function automatic void emit_sum();
    logic [SUM_W-1:0]   doubled;
    lta_pkg::out_word_t wd;
    doubled = term_sum << 1;
    for (int k = 0; k < ACC_WORDS; k++) begin
      wd.word_index = lta_pkg::WIDX_W'(k);
      wd.word_value = doubled[lta_pkg::WORD_W*k +: lta_pkg::WORD_W];
      wd.last_word  = (k == ACC_WORDS - 1);
      sum_words_due.push_back(wd);
    end
    term_sum = '0;
  endfunction

  // --------------------------------------------------------------------------
  // Result monitor: sample at the rising edge, compare against the oldest
  // expectation, keep going after a mismatch.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sum_words_due.size() == 0) begin
        $error("unexpected result word: index %0d value %h last %0b",
               out_data.word_index, out_data.word_value, out_data.last_word);
        err_count++;
      end else begin
        due_w = sum_words_due.pop_front();
        if (out_data.word_index !== due_w.word_index) begin
          $error("word_index: expected %0d, got %0d",
                 due_w.word_index, out_data.word_index);
          err_count++;
        end
        if (out_data.word_value !== due_w.word_value) begin
          $error("word_value: expected %h, got %h",
                 due_w.word_value, out_data.word_value);
          err_count++;
        end
        if (out_data.last_word !== due_w.last_word) begin
          $error("last_word: expected %0b, got %0b",
                 due_w.last_word, out_data.last_word);
          err_count++;
        end
      end
    end
  end

  // Receiver back-pressure: drop ready at random, in bursts of random length
  initial begin
    forever begin
      @(negedge clk);
      if (stall_en && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Offer one point; hold valid and the word until it is taken, then predict.
  task automatic send_point(input logic [lta_pkg::ROW_W-1:0] row,
                            input logic [lta_pkg::LOW_W-1:0] low,
                            input logic                      last);
    lta_pkg::in_word_t wd;
    wd.row_code   = row;
    wd.low_index  = low;
    wd.last_point = last;
    @(negedge clk);
    if (stall_en && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_data  = wd;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fold_point(row, low);
    if (last) emit_sum();
  endtask

  // Drop valid, wait for every owed word, then let an in-flight point finish
  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (sum_words_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Single-cycle register write; mirror it in the shadow copy
  task automatic write_reg(input logic [lta_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [lta_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      lta_pkg::CFG_ORDER_N:       order_q  = data[lta_pkg::ORDER_W-1:0];
      lta_pkg::CFG_PREFIX_HIGH:   prefix_q = data[lta_pkg::PREFIX_W-1:0];
      lta_pkg::CFG_LOW_BIT_COUNT: lbc_q    = data[lta_pkg::LBC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int n, input logic [lta_pkg::PREFIX_W-1:0] prefix,
                            input int k);
    settle_block();
    write_reg(lta_pkg::CFG_ORDER_N, lta_pkg::CFG_DATA_W'(n));
    write_reg(lta_pkg::CFG_PREFIX_HIGH, prefix);
    write_reg(lta_pkg::CFG_LOW_BIT_COUNT, lta_pkg::CFG_DATA_W'(k));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: skip rules, field extremes, emission and clearing
  task automatic test_directed_points();
    send_point('0, '0, 1'b0);                  // v equals u at zero: skip
    send_point(ROW_MAX, LOW_MAX, 1'b0);        // index masked to seven bits
    send_point(30'd1, '0, 1'b0);               // smallest kept point
    send_point(30'd100, 20'd100, 1'b1);        // skipped last still emits
    send_point('0, '0, 1'b1);                  // fresh sum: all zero words
    send_point(30'h2AAAAAAA, 20'h55555, 1'b0);
    send_point(30'h15555555, 20'h2AAAA, 1'b1);
  endtask

  // Order clamping at the low end, and the largest orders
  task automatic test_order_limits();
    settle_block();
    // upper data bits are dropped, leaving order 0, which acts as 2
    write_reg(lta_pkg::CFG_ORDER_N, 30'h3FFFFFE0);
    send_point(30'h2AAAAAAA, 20'h55555, 1'b1);
    settle_block();
    write_reg(lta_pkg::CFG_ORDER_N, 30'd1);
    send_point(30'h15555555, 20'h2AAAA, 1'b1);
    // all-zero sequence: every correlation is at its maximum and the
    // product runs past 160 bits, so both product and sum wrap
    set_config(30, '0, 7);
    send_point(30'h20000000, '0, 1'b0);
    send_point(30'h20000000, '0, 1'b1);
    set_config(MAX_ORDER, '0, 7);
    send_point(ROW_MAX, '0, 1'b1);
  endtask

  // Low bit counts from zero up past the width of the index
  task automatic test_low_count_limits();
    set_config(7, PREFIX_MAX, 0);
    send_point(ROW_MAX, LOW_MAX, 1'b1);        // v equals u: skip
    set_config(7, '0, 20);
    send_point(ROW_MAX, LOW_MAX, 1'b0);
    send_point(30'd1, '0, 1'b1);
    // prefix bit 0 lands on v bit 31: v can never be below u
    set_config(9, PREFIX_MAX, 31);
    send_point(ROW_MAX, LOW_MAX, 1'b0);
    // prefix shifted out of range entirely: v is the index alone
    set_config(9, 30'd2, 31);
    send_point(30'h100000, LOW_MAX, 1'b1);
    set_config(5, 30'd1, 21);
    send_point(ROW_MAX, 20'h12345, 1'b1);
  endtask

  // A write to an unused index must leave every register alone
  task automatic test_spare_index();
    settle_block();
    write_reg(CFG_SPARE_IDX, PREFIX_MAX);
    send_point(ROW_MAX, 20'h0ABCD, 1'b1);
  endtask

  // Random points over several settings; mostly kept points, with a share of
  // small rows and rows right at v to exercise the skip boundary
  task automatic test_random_sweep();
    int                           n;
    int                           k;
    logic [lta_pkg::PREFIX_W-1:0] prefix;
    logic [lta_pkg::ROW_W-1:0]    row;
    logic [lta_pkg::LOW_W-1:0]    low;
    logic [lta_pkg::V_W-1:0]      v;
    logic                         last;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          n = 2;
          k = 0;
        end
        1: begin
          n = MAX_ORDER;
          k = 20;
        end
        default: begin
          n = $urandom_range(2, MAX_ORDER);
          k = $urandom_range(0, 20);
        end
      endcase
      // keep v below 2^29 so that most rows clear it
      prefix = lta_pkg::PREFIX_W'($urandom_range(0, (1 << (29 - k)) - 1));
      set_config(n, prefix, k);
      // final stretch runs with no idling on either side
      if (p == 5) stall_en = 1'b0;
      for (int c = 0; c < 72; c++) begin
        low = lta_pkg::LOW_W'($urandom);
        v   = v_of(low);
        case ($urandom_range(0, 9))
          0: row = lta_pkg::ROW_W'($urandom_range(0, 255));
          1: row = (v < {2'b00, ROW_MAX}) ?
                   lta_pkg::ROW_W'(v + lta_pkg::V_W'($urandom_range(0, 1))) : ROW_MAX;
          2, 3, 4: row = lta_pkg::ROW_W'($urandom);
          default: row = lta_pkg::ROW_W'($urandom) |
                         (lta_pkg::ROW_W'(1) << (lta_pkg::ROW_W - 1));
        endcase
        last = (c == 71) || ($urandom_range(0, 7) == 0);
        send_point(row, low, last);
        // hold off once until every owed word has come back
        if (p == 2 && c == 35) settle_block();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = lta_pkg::CFG_ORDER_N;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b1;
    stall_en  = 1'b1;
    err_count = 0;
    term_sum  = '0;
    order_q   = lta_pkg::ORDER_RST;
    prefix_q  = '0;
    lbc_q     = lta_pkg::LBC_RST;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_directed_points();
    test_order_limits();
    test_low_count_limits();
    test_spare_index();
    test_random_sweep();

    // drain, then allow for any stray words before judging
    settle_block();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
